// ----- rtl/core/melody_note_sequencer_defines.svh -----
// Assertion macros used by the melody sequencer checker.
`ifndef MELODY_NOTE_SEQUENCER_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk and muted while rst_n is low.
`define MNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and muted while rst_n is low.
`define MNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mns_pkg.sv -----
// Shared types, widths and constants of the melody note sequencer.
package mns_pkg;

  // Field widths of the input and result beats.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 5;
  localparam int FREQ_W   = 16;
  localparam int DIV_W    = 8;
  localparam int TIME_W   = 32;
  localparam int DUR_W    = 10;
  localparam int ENTRY_W  = FREQ_W + DIV_W;

  // Default number of melody table entries.
  localparam int TABLE_DEPTH_DEF = 32;

  // A note lasts NOTE_MS_NUM / divisor milliseconds.
  localparam int NOTE_MS_NUM = 1000;

  // A note is over once ELAPSED_SCALE * elapsed > DURATION_SCALE * duration.
  localparam int ELAPSED_SCALE  = 10;
  localparam int DURATION_SCALE = 13;

  // Input beat operation codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_TICK    = 2'd2
  } action_t;

  // Request to the duration divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // Response of the duration divider.
  typedef struct packed {
    logic             done;
    logic [DUR_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/mns_in_if.sv -----
// Input channel of the melody sequencer: valid, ready and the command payload.
interface mns_in_if;
  logic                             valid;
  logic                             ready;
  logic [mns_pkg::ACTION_W-1:0]     action;
  logic [mns_pkg::INDEX_W-1:0]      entry_index;
  logic [mns_pkg::FREQ_W-1:0]       entry_note;
  logic [mns_pkg::DIV_W-1:0]        entry_divisor;
  logic [mns_pkg::TIME_W-1:0]       current_time;

  modport source (
    output valid, action, entry_index, entry_note, entry_divisor, current_time,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, entry_note, entry_divisor, current_time,
    output ready
  );
endinterface

// ----- rtl/core/mns_out_if.sv -----
// Result channel of the melody sequencer: valid, ready and the tone commands.
interface mns_out_if;
  logic                         valid;
  logic                         ready;
  logic                         tone_stop;
  logic                         tone_start;
  logic [mns_pkg::FREQ_W-1:0]   tone_frequency;
  logic [mns_pkg::DUR_W-1:0]    tone_duration_ms;
  logic                         playing;

  modport source (
    output valid, tone_stop, tone_start, tone_frequency, tone_duration_ms, playing,
    input  ready
  );

  modport sink (
    input  valid, tone_stop, tone_start, tone_frequency, tone_duration_ms, playing,
    output ready
  );
endinterface

// ----- rtl/core/mns_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module mns_ram #(
  parameter  int WIDTH = mns_pkg::ENTRY_W,
  parameter  int DEPTH = mns_pkg::TABLE_DEPTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/mns_div.sv -----
// Restoring divider that turns a note divisor into a duration of 1000/divisor ms.
module mns_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mns_pkg::div_req_t req,
  output mns_pkg::div_rsp_t rsp
);

  localparam int STEPS = mns_pkg::DUR_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [STEPS-1:0] NUM = STEPS'(mns_pkg::NOTE_MS_NUM);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [mns_pkg::DIV_W:0]   rem_r;
  logic [STEPS-1:0]          quo_r;
  logic [mns_pkg::DIV_W-1:0] dsr_r;

  logic [CNT_W-1:0]          bit_idx;
  logic [mns_pkg::DIV_W:0]   rem_trial;
  logic                      fits;
  logic [mns_pkg::DIV_W:0]   rem_nxt;

  // One quotient bit per cycle, most significant first.
  assign bit_idx   = CNT_W'(STEPS - 1) - cnt_r;
  assign rem_trial = {rem_r[mns_pkg::DIV_W-1:0], NUM[bit_idx]};
  assign fits      = (rem_trial >= {1'b0, dsr_r});
  assign rem_nxt   = fits ? (rem_trial - {1'b0, dsr_r}) : rem_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= '0;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[STEPS-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // An end note (divisor zero) has no duration.
  assign rsp.done     = done_r;
  assign rsp.quotient = (dsr_r == '0) ? '0 : quo_r;

endmodule

// ----- rtl/core/melody_note_sequencer.sv -----
// Melody note sequencer: plays a table of notes as tone stop/start commands.
//
// Channels: in_ch carries one command beat (write a table entry, restart the
// melody, or a millisecond tick); out_ch returns exactly one result beat per
// command with the tone stop/start commands and the playing flag.
// Path: a write, an unused action or a tick that finds nothing playing goes
// through DECODE and RESULT; a tick that does not advance through DECODE,
// COMPARE and RESULT; a restart or first tick through DECODE, DIV_WAIT (the
// 10-step duration divider) and RESULT; an advancing tick through DECODE,
// COMPARE, READ and DIV_WAIT to RESULT. One command is worked on at a time;
// the next is accepted once the previous result sits in the output register.
// Reset: the table reads as all zero (valid bit per entry), nothing plays until
// a restart, and no result is pending. No clearing pass is needed.
// Stall: a result waits in the output register while out_ch.ready is low; the
// block finishes the next command up to its result and then holds.
module melody_note_sequencer #(
  parameter int TABLE_DEPTH = mns_pkg::TABLE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  mns_in_if.sink   in_ch,
  mns_out_if.source out_ch
);

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int POS_W   = $clog2(TABLE_DEPTH + 1);
  localparam int SCALE_W = mns_pkg::TIME_W + 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_COMPARE,
    ST_READ,
    ST_DIV_WAIT,
    ST_RESULT
  } state_t;

  state_t state_r;

  // Latched command beat.
  logic [mns_pkg::ACTION_W-1:0] item_action_r;
  logic [mns_pkg::INDEX_W-1:0]  item_index_r;
  logic [mns_pkg::FREQ_W-1:0]   item_note_r;
  logic [mns_pkg::DIV_W-1:0]    item_div_r;
  logic [mns_pkg::TIME_W-1:0]   item_time_r;

  // Playback state.
  logic [POS_W-1:0]             pos_r;
  logic                         first_r;
  logic                         finished_r;
  logic [mns_pkg::TIME_W-1:0]   start_time_r;
  logic [mns_pkg::FREQ_W-1:0]   held_freq_r;
  logic [mns_pkg::DUR_W-1:0]    held_dur_r;
  logic [mns_pkg::TIME_W-1:0]   elapsed_r;
  logic [TABLE_DEPTH-1:0]       valid_r;
  logic [mns_pkg::FREQ_W-1:0]   e0_freq_r;
  logic [mns_pkg::DIV_W-1:0]    e0_div_r;
  logic                         rd_ok_r;
  logic                         div_tick_r;

  // Result being built and the output register.
  logic                         res_stop_r;
  logic                         res_start_r;
  logic [mns_pkg::FREQ_W-1:0]   res_freq_r;
  logic [mns_pkg::DUR_W-1:0]    res_dur_r;
  logic                         out_valid_r;
  logic                         out_stop_r;
  logic                         out_start_r;
  logic [mns_pkg::FREQ_W-1:0]   out_freq_r;
  logic [mns_pkg::DUR_W-1:0]    out_dur_r;
  logic                         out_playing_r;

  mns_pkg::div_req_t            div_req_r;
  mns_pkg::div_rsp_t            div_rsp;

  logic                         wr_en;
  logic                         wr_in_range;
  logic [AW-1:0]                wr_addr;
  logic [POS_W-1:0]             pos_nxt;
  logic                         rd_in_range;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [mns_pkg::ENTRY_W-1:0]  rd_data;
  logic [mns_pkg::ENTRY_W-1:0]  rd_entry;
  logic [SCALE_W-1:0]           elapsed_x;
  logic [SCALE_W-1:0]           dur_x;
  logic                         note_over;

  assign in_ch.ready = (state_r == ST_IDLE);

  // Table writes happen while decoding a write beat; reads are issued by a
  // later beat, so a read never meets a write to the same entry in flight.
  assign wr_in_range = (32'(item_index_r) < TABLE_DEPTH);
  assign wr_addr     = AW'(item_index_r);
  assign wr_en       = (state_r == ST_DECODE) &&
                       (mns_pkg::action_t'(item_action_r) == mns_pkg::ACT_WRITE) &&
                       wr_in_range;

  // Next note address and the note-over compare.
  assign pos_nxt     = pos_r + 1'b1;
  assign rd_in_range = (32'(pos_nxt) < TABLE_DEPTH);
  assign rd_addr     = AW'(pos_nxt);
  assign elapsed_x   = SCALE_W'(elapsed_r) * SCALE_W'(mns_pkg::ELAPSED_SCALE);
  assign dur_x       = SCALE_W'(held_dur_r) * SCALE_W'(mns_pkg::DURATION_SCALE);
  assign note_over   = (elapsed_x > dur_x);
  assign rd_en       = (state_r == ST_COMPARE) && note_over && rd_in_range;

  // Entries never written and reads past the table are end notes.
  assign rd_entry    = rd_ok_r ? rd_data : '0;

  mns_ram #(
    .WIDTH (mns_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({item_note_r, item_div_r}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  // Command sequencer with the playback state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      pos_r             <= '0;
      first_r           <= 1'b0;
      finished_r        <= 1'b1;
      start_time_r      <= '0;
      held_freq_r       <= '0;
      held_dur_r        <= '0;
      valid_r           <= '0;
      e0_freq_r         <= '0;
      e0_div_r          <= '0;
      div_req_r.start   <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      // The result beat leaves unless a new one replaces it in this cycle.
      if (out_valid_r && out_ch.ready && (state_r != ST_RESULT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            item_action_r <= in_ch.action;
            item_index_r  <= in_ch.entry_index;
            item_note_r   <= in_ch.entry_note;
            item_div_r    <= in_ch.entry_divisor;
            item_time_r   <= in_ch.current_time;
            res_stop_r    <= 1'b0;
            res_start_r   <= 1'b0;
            res_freq_r    <= '0;
            res_dur_r     <= '0;
            state_r       <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          case (mns_pkg::action_t'(item_action_r))
            mns_pkg::ACT_WRITE: begin
              if (wr_in_range) begin
                valid_r[wr_addr] <= 1'b1;
                if (item_index_r == '0) begin
                  e0_freq_r <= item_note_r;
                  e0_div_r  <= item_div_r;
                end
              end
              state_r <= ST_RESULT;
            end
            mns_pkg::ACT_RESTART: begin
              pos_r             <= '0;
              first_r           <= 1'b0;
              finished_r        <= 1'b0;
              held_freq_r       <= e0_freq_r;
              div_req_r.start   <= 1'b1;
              div_req_r.divisor <= e0_div_r;
              div_tick_r        <= 1'b0;
              res_stop_r        <= 1'b1;
              state_r           <= ST_DIV_WAIT;
            end
            mns_pkg::ACT_TICK: begin
              if (finished_r || (e0_div_r == '0)) begin
                state_r <= ST_RESULT;
              end else if (pos_r >= POS_W'(TABLE_DEPTH)) begin
                finished_r <= 1'b1;
                res_stop_r <= 1'b1;
                state_r    <= ST_RESULT;
              end else if (!first_r) begin
                // First tick after a restart reloads entry 0.
                held_freq_r       <= e0_freq_r;
                div_req_r.start   <= 1'b1;
                div_req_r.divisor <= e0_div_r;
                div_tick_r        <= 1'b1;
                res_stop_r        <= 1'b1;
                start_time_r      <= item_time_r;
                first_r           <= 1'b1;
                state_r           <= ST_DIV_WAIT;
              end else begin
                elapsed_r <= item_time_r - start_time_r;
                state_r   <= ST_COMPARE;
              end
            end
            default: begin
              state_r <= ST_RESULT;
            end
          endcase
        end

        ST_COMPARE: begin
          if (note_over) begin
            res_stop_r   <= 1'b1;
            start_time_r <= item_time_r;
            pos_r        <= pos_nxt;
            rd_ok_r      <= rd_in_range && valid_r[rd_addr];
            state_r      <= ST_READ;
          end else begin
            state_r <= ST_RESULT;
          end
        end

        ST_READ: begin
          held_freq_r       <= rd_entry[mns_pkg::ENTRY_W-1:mns_pkg::DIV_W];
          div_req_r.start   <= 1'b1;
          div_req_r.divisor <= rd_entry[mns_pkg::DIV_W-1:0];
          div_tick_r        <= 1'b1;
          state_r           <= ST_DIV_WAIT;
        end

        ST_DIV_WAIT: begin
          // The divider has taken the request by now.
          div_req_r.start <= 1'b0;
          if (div_rsp.done) begin
            held_dur_r <= div_rsp.quotient;
            // A tick starts the loaded note unless it is an end note.
            if (div_tick_r && (div_rsp.quotient != '0)) begin
              res_start_r <= 1'b1;
              res_freq_r  <= held_freq_r;
              res_dur_r   <= div_rsp.quotient;
            end
            state_r <= ST_RESULT;
          end
        end

        ST_RESULT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_stop_r    <= res_stop_r;
            out_start_r   <= res_start_r;
            out_freq_r    <= res_freq_r;
            out_dur_r     <= res_dur_r;
            out_playing_r <= !finished_r && (e0_div_r != '0);
            state_r       <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.tone_stop        = out_stop_r;
  assign out_ch.tone_start       = out_start_r;
  assign out_ch.tone_frequency   = out_freq_r;
  assign out_ch.tone_duration_ms = out_dur_r;
  assign out_ch.playing          = out_playing_r;

endmodule

// ----- rtl/core/mns_checker.sv -----
// Port-level checker of the melody sequencer and its bind to the top level.
`include "melody_note_sequencer_defines.svh"

module mns_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       tone_stop,
  input logic                       tone_start,
  input logic [mns_pkg::FREQ_W-1:0] tone_frequency,
  input logic [mns_pkg::DUR_W-1:0]  tone_duration_ms,
  input logic                       playing
);

  // A stalled result beat keeps its contents.
  `MNS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(tone_stop) && $stable(tone_start) &&
    $stable(tone_frequency) && $stable(tone_duration_ms) && $stable(playing),
    "stalled result beat changed")

  // A new tone always comes with a stop of the running one in the same beat.
  `MNS_ASSERT_NOW(a_start_has_stop, out_valid && tone_start, tone_stop,
    "tone start without tone stop")

  // A started tone has a length and leaves the melody playing.
  `MNS_ASSERT_NOW(a_start_playing, out_valid && tone_start,
    (tone_duration_ms != '0) && playing,
    "started tone with no duration or melody not playing")

  // Commands are worked on one at a time.
  `MNS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "command accepted while the previous one is in work")

endmodule

bind melody_note_sequencer mns_checker u_mns_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .tone_stop        (out_ch.tone_stop),
  .tone_start       (out_ch.tone_start),
  .tone_frequency   (out_ch.tone_frequency),
  .tone_duration_ms (out_ch.tone_duration_ms),
  .playing          (out_ch.playing)
);
